// ===== rtl/core/gat_pkg.sv =====
// Shared types and constants for the grid autotile neighbor mask block.
package gat_pkg;

    localparam int CELL_W       = 8;
    localparam int ROW_IDX_W    = 10;
    localparam int COL_IDX_W    = 6;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_MODE_W   = 2;
    localparam int CFG_WIDTH_W  = 7;
    localparam int CFG_HEIGHT_W = 11;

    localparam int CFG_WIDTH_RST = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

    localparam logic [CFG_MODE_W-1:0] MODE_OUTDOOR    = 2'd0;
    localparam logic [CFG_MODE_W-1:0] MODE_INDOOR     = 2'd1;
    localparam logic [CFG_MODE_W-1:0] MODE_PLATFORMER = 2'd2;

    // action field: a map cell; anything else is a flush beat
    localparam logic ACT_CELL = 1'b0;

    localparam logic [CELL_W-1:0] CELL_WALL  = 8'h31;  // '1'
    localparam logic [CELL_W-1:0] CELL_EMPTY = 8'h30;  // '0'
    localparam logic [CELL_W-1:0] TILE_BASE  = 8'h40;
    localparam logic [CELL_W-1:0] TILE_BIAS  = 8'h01;

    typedef struct packed {
        logic              action;
        logic [CELL_W-1:0] cell_req;
    } t_in_beat;

    typedef struct packed {
        logic [CELL_W-1:0]    tile;
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_IDX_W-1:0] column_index;
        logic                 last_of_map;
    } t_out_beat;

    // position of the released cell relative to the map border
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
    } t_edge;

    // occupancy of the four neighbors as seen inside the map
    typedef struct packed {
        logic left;
        logic up;
        logic right;
        logic down;
    } t_nbr;

endpackage

// ===== rtl/core/gat_ram.sv =====
// Generic simple-dual-port RAM: one write port, two registered read ports.
module gat_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-first; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/core/gat_tile_code.sv =====
// Tile code from neighbor occupancy, map edge position and border rule.
module gat_tile_code (
    input  logic [gat_pkg::CELL_W-1:0]     i_cell,
    input  logic [gat_pkg::CFG_MODE_W-1:0] i_mode,
    input  gat_pkg::t_edge                 i_edge,
    input  gat_pkg::t_nbr                  i_nbr,
    output logic [gat_pkg::CELL_W-1:0]     o_tile
);
    import gat_pkg::*;

    logic       lf;
    logic       up;
    logic       rt;
    logic       dn;
    logic [3:0] mask;

    always_comb begin
        lf = !i_edge.first_col && i_nbr.left;
        up = !i_edge.first_row && i_nbr.up;
        rt = !i_edge.last_col  && i_nbr.right;
        dn = !i_edge.last_row  && i_nbr.down;
        unique case (i_mode)
            MODE_INDOOR: begin
                up = up || (i_edge.first_row && !i_edge.last_col && !i_edge.first_col);
                rt = rt || (i_edge.last_col && !i_edge.first_row && !i_edge.last_row);
                dn = dn || (i_edge.last_row && !i_edge.last_col && !i_edge.first_col);
                lf = lf || (i_edge.first_col && !i_edge.first_row && !i_edge.last_row);
            end
            MODE_PLATFORMER: begin
                up = up || i_edge.first_row;
                rt = rt || i_edge.last_col;
                dn = dn || i_edge.last_row;
                lf = lf || i_edge.first_col;
            end
            default: begin
                // outdoor, and the unused code: outside is empty
            end
        endcase
        mask   = {dn, rt, up, lf};
        o_tile = (i_cell == CELL_WALL) ? ((TILE_BASE | {4'b0000, mask}) + TILE_BIAS)
                                       : i_cell;
    end

endmodule

// ===== rtl/core/grid_autotile_neighbor_mask.sv =====
// Top level: raster-order autotiler with a one-row line buffer in RAM.
// A result beat passes the RAM read / stage 1 register, then the output register.
// Throughput: one beat per cycle unless the output stalls; set by the RAM
//   read-modify-write loop.
// Reset: counters and the left-occupancy flag clear, mode = outdoor, width = 64,
//   height = 1. The line buffer RAM is not cleared: every entry is written before use.
module grid_autotile_neighbor_mask #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  gat_pkg::t_in_beat                i_in_beat,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output gat_pkg::t_out_beat               o_out_beat,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gat_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [gat_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gat_pkg::*;

    // column address, width/height counters able to hold the full size
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int WCW    = $clog2(MAX_WIDTH + 1);
    localparam int HCW    = $clog2(MAX_HEIGHT + 1);
    localparam int WORD_W = CELL_W + 1;   // {above occupied, pending byte}
    localparam int RST_W  = (MAX_WIDTH < CFG_WIDTH_RST) ? MAX_WIDTH : CFG_WIDTH_RST;

    typedef struct packed {
        logic              wr;     // cell beat: writes the line buffer
        logic              rel;    // releases a cell to the output
        logic              last;   // final cell of the map
        logic              down;   // occupancy of the cell below
        logic [XW-1:0]     x;
        logic [HCW-1:0]    y;
        logic [CELL_W-1:0] cell_byte;
        t_edge             edges;
    } t_s1;

    // ---------------------------------------------------------------
    // Configuration. Width and height are stored already saturated.
    // ---------------------------------------------------------------
    logic [CFG_MODE_W-1:0] r_mode;
    logic [WCW-1:0]        r_w;
    logic [HCW-1:0]        r_h;
    logic [WCW-1:0]        n_w;
    logic [HCW-1:0]        n_h;
    logic                  cfg_we;
    logic                  cfg_mode_we;
    logic                  cfg_w_we;
    logic                  cfg_h_we;
    logic                  cfg_clear;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        cfg_mode_we = 1'b0;
        cfg_w_we    = 1'b0;
        cfg_h_we    = 1'b0;
        unique case (i_cfg_index)
            CFG_IDX_MODE:   cfg_mode_we = cfg_we;
            CFG_IDX_WIDTH:  cfg_w_we    = cfg_we;
            CFG_IDX_HEIGHT: cfg_h_we    = cfg_we;
            default: begin
                // unknown register: write dropped
            end
        endcase
    end

    // a new width or height abandons the map in progress
    assign cfg_clear = cfg_w_we || cfg_h_we;

    always_comb begin
        if (i_cfg_data[CFG_WIDTH_W-1:0] == '0) begin
            n_w = WCW'(1);
        end else if (int'(i_cfg_data[CFG_WIDTH_W-1:0]) > MAX_WIDTH) begin
            n_w = WCW'(MAX_WIDTH);
        end else begin
            n_w = WCW'(i_cfg_data[CFG_WIDTH_W-1:0]);
        end
        if (i_cfg_data[CFG_HEIGHT_W-1:0] == '0) begin
            n_h = HCW'(1);
        end else if (int'(i_cfg_data[CFG_HEIGHT_W-1:0]) > MAX_HEIGHT) begin
            n_h = HCW'(MAX_HEIGHT);
        end else begin
            n_h = HCW'(i_cfg_data[CFG_HEIGHT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OUTDOOR;
            r_w    <= WCW'(RST_W);
            r_h    <= HCW'(1);
        end else begin
            if (cfg_mode_we) begin
                r_mode <= i_cfg_data[CFG_MODE_W-1:0];
            end
            if (cfg_w_we) begin
                r_w <= n_w;
            end
            if (cfg_h_we) begin
                r_h <= n_h;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: decode the beat against the raster counters and issue
    // the line buffer reads at x (self + above) and x+1 (right).
    // ---------------------------------------------------------------
    logic [XW-1:0]  r_col;
    logic [HCW-1:0] r_row;
    logic [XW-1:0]  r_flush;

    logic           in_acc;
    logic           s0_cell;
    logic           s0_cell_ok;
    logic           s0_flush_ok;
    logic           s0_col_last;
    logic           s0_flush_last;
    logic           s0_load;
    logic [XW-1:0]  s0_x;
    logic [HCW-1:0] s0_y;
    logic [XW-1:0]  s0_raddr_b;
    t_s1            s0;

    assign in_acc        = i_in_valid && !o_in_stall;
    assign s0_cell       = (i_in_beat.action == ACT_CELL);
    assign s0_col_last   = (WCW'(r_col) + WCW'(1)) >= r_w;
    assign s0_flush_last = (WCW'(r_flush) + WCW'(1)) >= r_w;
    // cells past the last row and flushes before it are dropped silently
    assign s0_cell_ok    = s0_cell && (r_row < r_h);
    assign s0_flush_ok   = !s0_cell && (r_row >= r_h);
    assign s0_load       = in_acc && (s0_cell_ok || s0_flush_ok);

    assign s0_x       = s0_cell ? r_col : r_flush;
    assign s0_y       = s0_cell ? (r_row - HCW'(1)) : (r_h - HCW'(1));
    assign s0_raddr_b = (s0_x == XW'(MAX_WIDTH - 1)) ? '0 : (s0_x + XW'(1));

    always_comb begin
        s0.wr              = s0_cell;
        s0.rel             = s0_flush_ok || (r_row != '0);
        s0.last            = !s0_cell && s0_flush_last;
        s0.down            = s0_cell && (i_in_beat.cell_req != CELL_EMPTY);
        s0.x               = s0_x;
        s0.y               = s0_y;
        s0.cell_byte       = i_in_beat.cell_req;
        s0.edges.first_col = (s0_x == '0);
        s0.edges.last_col  = s0_cell ? s0_col_last : s0_flush_last;
        s0.edges.first_row = (s0_y == '0);
        // a cell beat only ever releases a row above the last one
        s0.edges.last_row  = !s0_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else if (cfg_clear) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else if (s0_load) begin
            if (s0_cell_ok) begin
                if (s0_col_last) begin
                    r_col <= '0;
                    r_row <= r_row + HCW'(1);
                end else begin
                    r_col <= r_col + XW'(1);
                end
            end else if (s0_flush_last) begin
                // end of map: next cell starts a new one
                r_col   <= '0;
                r_row   <= '0;
                r_flush <= '0;
            end else begin
                r_flush <= r_flush + XW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Line buffer: entry x = {occupancy of row y-1, raw byte of row y}.
    // ---------------------------------------------------------------
    logic              r_s1_valid;
    t_s1               r_s1;
    logic              s1_we;
    logic [WORD_W-1:0] s1_wdata;
    logic [WORD_W-1:0] ram_a;
    logic [WORD_W-1:0] ram_b;

    gat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (s1_we),
        .i_waddr   (r_s1.x),
        .i_wdata   (s1_wdata),
        .i_re      (s0_load),
        .i_raddr_a (s0_x),
        .i_raddr_b (s0_raddr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // ---------------------------------------------------------------
    // Stage 1: tile compute and write-back. The write lands in the same
    // cycle as the next beat's read, so a same-address hit is forwarded
    // (narrow maps: width 1 or 2, and the row wrap).
    // ---------------------------------------------------------------
    logic              r_fwd_a;
    logic              r_fwd_b;
    logic [WORD_W-1:0] r_fwd_word;
    logic              r_left_occ;

    logic              s1_out_free;
    logic              s1_go;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [CELL_W-1:0] s1_cur;
    logic              s1_cur_occ;
    t_nbr              s1_nbr;
    logic [CELL_W-1:0] s1_tile;

    logic              r_out_valid;
    t_out_beat         r_out;

    assign s1_out_free = !r_out_valid || !i_out_stall;
    // beats that only fill row 0 never wait on the output register
    assign s1_go       = r_s1_valid && (!r_s1.rel || s1_out_free);
    assign o_in_stall  = r_s1_valid && !s1_go;

    assign word_a     = r_fwd_a ? r_fwd_word : ram_a;
    assign word_b     = r_fwd_b ? r_fwd_word : ram_b;
    assign s1_cur     = word_a[CELL_W-1:0];
    assign s1_cur_occ = (s1_cur != CELL_EMPTY);

    assign s1_nbr.left  = r_left_occ;
    assign s1_nbr.up    = word_a[CELL_W];
    assign s1_nbr.right = (word_b[CELL_W-1:0] != CELL_EMPTY);
    assign s1_nbr.down  = r_s1.down;

    assign s1_we    = s1_go && r_s1.wr;
    assign s1_wdata = {s1_cur_occ, r_s1.cell_byte};

    gat_tile_code u_tile_code (
        .i_cell (s1_cur),
        .i_mode (r_mode),
        .i_edge (r_s1.edges),
        .i_nbr  (s1_nbr),
        .o_tile (s1_tile)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s0_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go || in_acc) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_load) begin
            r_s1       <= s0;
            r_fwd_a    <= s1_we && (r_s1.x == s0_x);
            r_fwd_b    <= s1_we && (r_s1.x == s0_raddr_b);
            r_fwd_word <= s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_occ <= 1'b0;
        end else if (cfg_clear) begin
            r_left_occ <= 1'b0;
        end else if (s1_go && r_s1.rel) begin
            r_left_occ <= s1_cur_occ && !r_s1.last;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1.rel) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.rel) begin
            r_out.tile         <= s1_tile;
            r_out.row_index    <= ROW_IDX_W'(r_s1.y);
            r_out.column_index <= COL_IDX_W'(r_s1.x);
            r_out.last_of_map  <= r_s1.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_col_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WCW'(r_col) < r_w) && (WCW'(r_flush) < r_w))
        else $error("raster column beyond map width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_h)
        else $error("row counter beyond map height");

    a_flush_after_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush != '0) |-> (r_row == r_h))
        else $error("flush in progress before the last row arrived");

    a_release_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1.rel) |=> r_out_valid)
        else $error("released cell did not reach the output register");

endmodule

// ===== sim/grid_autotile_neighbor_mask_tb.sv =====
// Self-checking testbench for the grid autotile neighbor mask block.
module grid_autotile_neighbor_mask_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gat_pkg::*;

    localparam int MAX_W       = 64;
    localparam int MAX_H       = 1024;
    localparam int RAND_BEATS  = 120;     // random cell/flush beats that do real work
    localparam int HOLD_CYCLES = 300;     // long output hold-off, fills the block
    localparam int SETTLE      = 4;       // pipeline is 2 deep; margin before a reg write
    localparam int DRAIN       = 8;       // quiet cycles after the last result
    localparam int CYCLE_LIMIT = 500_000;

    // index with no register behind it; the block ignores the write
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic ACT_FLUSH = ~ACT_CELL;

    // ---------------------------------------------------------------
    // Clock, reset, DUT
    // ---------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_in_beat               i_in_beat   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_beat              o_out_beat;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    always #6 i_clk = ~i_clk;

    grid_autotile_neighbor_mask #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Shared test state
    // ---------------------------------------------------------------
    t_out_beat tile_q [$];     // released cells still owed by the DUT
    int        fail_cnt    = 0;
    int        beats_taken = 0; // beats that moved the map along (not ignored)
    int        cycle_cnt   = 0;
    bit        calm        = 1'b0; // end of run: no idling on either side
    int        hold_asks   = 0;    // bumped by stimulus, served by the receiver
    int        hold_done   = 0;

    // ---------------------------------------------------------------
    // Autotile predictor: own copy of the registers and line buffer
    // ---------------------------------------------------------------
    logic [CFG_MODE_W-1:0]   mode_r   = MODE_OUTDOOR;
    logic [CFG_WIDTH_W-1:0]  width_r  = CFG_WIDTH_W'(CFG_WIDTH_RST);
    logic [CFG_HEIGHT_W-1:0] height_r = CFG_HEIGHT_W'(1);
    bit [CELL_W-1:0]         row_buf   [MAX_W];  // buffered row, raw bytes
    bit                      above_occ [MAX_W];  // occupancy of the row above it
    bit                      left_occ  = 1'b0;
    int                      col_cnt   = 0;
    int                      row_cnt   = 0;
    int                      flush_cnt = 0;

    // zero acts as one, oversize saturates
    function automatic int map_w();
        if (width_r == 0) return 1;
        if (width_r > MAX_W) return MAX_W;
        return int'(width_r);
    endfunction

    function automatic int map_h();
        if (height_r == 0) return 1;
        if (height_r > MAX_H) return MAX_H;
        return int'(height_r);
    endfunction

    // anything but '0' is occupied, 0x00 included
    function automatic bit occupied(logic [CELL_W-1:0] c);
        return c != CELL_EMPTY;
    endfunction

    function automatic void restart_map();
        left_occ  = 1'b0;
        col_cnt   = 0;
        row_cnt   = 0;
        flush_cnt = 0;
    endfunction

    // Give out buffered cell (x, y). down_occ only counts above the last row.
    function automatic t_out_beat emit_cell(int x, int y, bit down_occ, bit last);
        int              w;
        int              h;
        bit              fc, lc, fr, lr;
        bit              lf, up, rt, dn;
        logic [CELL_W-1:0] c;
        logic [3:0]      mask;
        t_out_beat       r;
        w = map_w();
        h = map_h();
        c = row_buf[x % MAX_W];
        r.tile = c;
        if (c == CELL_WALL) begin
            fc = (x == 0);
            lc = (x + 1 >= w);
            fr = (y == 0);
            lr = (y + 1 >= h);
            lf = !fc && left_occ;
            up = !fr && above_occ[x % MAX_W];
            rt = !lc && occupied(row_buf[(x + 1) % MAX_W]);
            dn = !lr && down_occ;
            if (mode_r == MODE_INDOOR) begin
                // edge cells get a wall bit on the side facing out, corners excepted
                up = up || (fr && !lc && !fc);
                rt = rt || (lc && !fr && !lr);
                dn = dn || (lr && !lc && !fc);
                lf = lf || (fc && !fr && !lr);
            end else if (mode_r == MODE_PLATFORMER) begin
                up = up || fr;
                rt = rt || lc;
                dn = dn || lr;
                lf = lf || fc;
            end
            mask   = {dn, rt, up, lf};
            r.tile = (TILE_BASE | {4'b0000, mask}) + TILE_BIAS;
        end
        r.row_index    = ROW_IDX_W'(y);
        r.column_index = COL_IDX_W'(x);
        r.last_of_map  = last;
        left_occ = occupied(c);
        return r;
    endfunction

    // One accepted input beat. took: the beat did work; made: a cell came out.
    task automatic autotile_step(input t_in_beat b, output bit took, output bit made,
                                 output t_out_beat res);
        int w;
        int h;
        int x;
        w    = map_w();
        h    = map_h();
        took = 1'b0;
        made = 1'b0;
        res  = '0;
        if (b.action == ACT_CELL) begin
            if (row_cnt >= h) return;          // map full, waiting on flush
            took = 1'b1;
            x    = col_cnt;
            if (row_cnt > 0) begin
                res  = emit_cell(x, row_cnt - 1, occupied(b.cell_req), 1'b0);
                made = 1'b1;
            end
            above_occ[x] = occupied(row_buf[x]);
            row_buf[x]   = b.cell_req;
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
        end else begin
            if (row_cnt < h) return;           // last row not in yet
            took = 1'b1;
            made = 1'b1;
            x    = flush_cnt;
            res  = emit_cell(x, h - 1, 1'b0, x + 1 >= w);
            flush_cnt++;
            if (x + 1 >= w) restart_map();
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers. All of them start and end at a falling edge.
    // ---------------------------------------------------------------
    function automatic t_in_beat cell_beat(logic [CELL_W-1:0] c);
        t_in_beat b;
        b.action   = ACT_CELL;
        b.cell_req = c;
        return b;
    endfunction

    // flush beats carry a random byte; the block must not care
    function automatic t_in_beat flush_beat();
        t_in_beat b;
        b.action   = ACT_FLUSH;
        b.cell_req = CELL_W'($urandom);
        return b;
    endfunction

    function automatic logic [CELL_W-1:0] rand_cell();
        logic [CELL_W-1:0] v;
        v = CELL_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CELL_WALL;
            4, 5, 6:    return CELL_EMPTY;
            7:          return 8'h00;
            8:          return 8'hFF;
            default:    return v;
        endcase
    endfunction

    // width register only keeps 7 bits; fill the rest with junk
    function automatic logic [CFG_DATA_W-1:0] width_word(int w);
        logic [CFG_DATA_W-1:0] v;
        v      = CFG_DATA_W'($urandom);
        v[6:0] = w[6:0];
        return v;
    endfunction

    // Send one beat, with an optional idle burst ahead of it. Valid stays up
    // after the beat is taken: the next call either puts a new beat on the
    // bus or drops valid, both at this same falling edge.
    task automatic feed(input t_in_beat b, input bit typed, input t_out_beat want);
        bit        took;
        bit        made;
        t_out_beat res;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        autotile_step(b, took, made, res);
        // a typed-in row overrides the predictor, but state still advances
        if (made) tile_q.push_back(typed ? want : res);
        if (took) beats_taken++;
        @(negedge i_clk);
    endtask

    // Register write, only with the block idle: every result in, then settle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        while (tile_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_IDX_MODE: mode_r = val[CFG_MODE_W-1:0];
            CFG_IDX_WIDTH: begin
                width_r = val[CFG_WIDTH_W-1:0];
                restart_map();
            end
            CFG_IDX_HEIGHT: begin
                height_r = val[CFG_HEIGHT_W-1:0];
                restart_map();
            end
            default: ;  // spare index, no effect
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One map at the current size. Noisy maps also get ignored beats
    // (early flushes, cells past the last row), mode changes between rows
    // and now and then an abandoned map.
    task automatic run_map(input bit noisy);
        int w;
        int h;
        w = map_w();
        h = map_h();
        for (int y = 0; y < h; y++) begin
            if (noisy && y > 0 && $urandom_range(0, 11) == 0)
                write_reg(CFG_IDX_MODE, CFG_DATA_W'($urandom_range(0, 2047)));
            for (int x = 0; x < w; x++) begin
                if (noisy && $urandom_range(0, 29) == 0)
                    feed(flush_beat(), 1'b0, '0);
                if (noisy && y > 0 && $urandom_range(0, 99) == 0) begin
                    // rewriting the height drops the map in progress
                    write_reg(CFG_IDX_HEIGHT, height_r);
                    return;
                end
                feed(cell_beat(rand_cell()), 1'b0, '0);
            end
        end
        for (int x = 0; x < w; x++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                feed(cell_beat(CELL_W'($urandom)), 1'b0, '0);
            feed(flush_beat(), 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    typedef enum logic {ROW_REG, ROW_BEAT} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        t_in_beat              beat;
        logic                  typed;   // want is filled in by hand
        t_out_beat             want;
    } t_dir_row;

    function automatic t_dir_row reg_row(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_dir_row beat_row(t_in_beat b);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_BEAT;
        r.beat = b;
        return r;
    endfunction

    function automatic t_dir_row checked_row(t_in_beat b, t_out_beat want);
        t_dir_row r;
        r       = beat_row(b);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    t_dir_row dir_tab [$];

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, one long hold on request
    // ---------------------------------------------------------------
    initial begin : out_stall_gen
        int n;
        @(negedge i_clk);
        forever begin
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                i_out_stall <= 1'b1;
                n = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                n = $urandom_range(1, 12);
            end else begin
                // open stretch, sometimes long
                i_out_stall <= 1'b0;
                n = calm ? 1 : $urandom_range(1, 24);
            end
            repeat (n) @(negedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Result checker: in order, field by field
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : out_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tile_q.size() == 0) begin
                $error("result beat with nothing expected: tile %0h row %0d col %0d",
                       o_out_beat.tile, o_out_beat.row_index, o_out_beat.column_index);
                fail_cnt++;
            end else begin
                want = tile_q.pop_front();
                if (o_out_beat.tile !== want.tile) begin
                    $error("tile: expected %0h, got %0h", want.tile, o_out_beat.tile);
                    fail_cnt++;
                end
                if (o_out_beat.row_index !== want.row_index) begin
                    $error("row_index: expected %0d, got %0d",
                           want.row_index, o_out_beat.row_index);
                    fail_cnt++;
                end
                if (o_out_beat.column_index !== want.column_index) begin
                    $error("column_index: expected %0d, got %0d",
                           want.column_index, o_out_beat.column_index);
                    fail_cnt++;
                end
                if (o_out_beat.last_of_map !== want.last_of_map) begin
                    $error("last_of_map: expected %0b, got %0b",
                           want.last_of_map, o_out_beat.last_of_map);
                    fail_cnt++;
                end
            end
        end
    end

    // hard stop if the DUT hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stim
        int base;

        // 1x1 maps read straight off the rules: platformer walls all round
        // give 0x50, outdoor gives the bare 0x41. Then an indoor 3x3 with
        // empty, 0x00 and pass-through bytes, and an all-wall 2x2.
        dir_tab = '{
            beat_row(flush_beat()),                       // flush at reset: ignored
            reg_row(CFG_IDX_WIDTH, 11'd0),                // zero width acts as one
            reg_row(CFG_IDX_HEIGHT, 11'd0),               // zero height acts as one
            reg_row(CFG_IDX_MODE, 11'h7FE),               // upper bits dropped
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(8'hA5)),                   // past last row: ignored
            checked_row(flush_beat(), '{8'h50, 10'd0, 6'd0, 1'b1}),
            reg_row(CFG_IDX_MODE, MODE_OUTDOOR),
            beat_row(cell_beat(CELL_WALL)),
            checked_row(flush_beat(), '{8'h41, 10'd0, 6'd0, 1'b1}),
            reg_row(CFG_IDX_SPARE, 11'h7FF),              // no such register
            reg_row(CFG_IDX_WIDTH, 11'd3),
            reg_row(CFG_IDX_HEIGHT, 11'd3),
            reg_row(CFG_IDX_MODE, MODE_INDOOR),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(CELL_EMPTY)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(8'h00)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(8'hFF)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(flush_beat()),
            beat_row(flush_beat()),
            beat_row(flush_beat()),
            reg_row(CFG_IDX_MODE, MODE_PLATFORMER),
            reg_row(CFG_IDX_WIDTH, 11'd2),
            reg_row(CFG_IDX_HEIGHT, 11'd2),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(cell_beat(CELL_WALL)),
            beat_row(flush_beat()),
            checked_row(flush_beat(), '{8'h50, 10'd1, 6'd1, 1'b1})
        };

        // synchronous reset, applied once
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                feed(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
        end

        // random maps, mostly small, all border modes (3 included)
        base = beats_taken;
        while (beats_taken - base < RAND_BEATS) begin
            case ($urandom_range(0, 5))
                0: write_reg(CFG_IDX_MODE, CFG_DATA_W'($urandom_range(0, 2047)));
                1: write_reg(CFG_IDX_WIDTH, width_word($urandom_range(0, 8)));
                2: write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
                3: begin
                    write_reg(CFG_IDX_WIDTH, width_word($urandom_range(0, 8)));
                    write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
                end
                default: ;
            endcase
            run_map(1'b1);
        end

        // full-width map (127 saturates to 64) with the output held off
        // long enough to back the block up into its input
        write_reg(CFG_IDX_WIDTH, 11'h7FF);
        write_reg(CFG_IDX_HEIGHT, 11'd2);
        write_reg(CFG_IDX_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        hold_asks++;
        run_map(1'b0);

        // tall one-column map: the width field reads zero and acts as one
        write_reg(CFG_IDX_WIDTH, 11'h780);
        write_reg(CFG_IDX_HEIGHT, 11'd24);
        run_map(1'b0);

        // tail with no idling on either side
        calm = 1'b1;
        write_reg(CFG_IDX_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        write_reg(CFG_IDX_WIDTH, 11'd5);
        write_reg(CFG_IDX_HEIGHT, 11'd4);
        run_map(1'b0);
        write_reg(CFG_IDX_WIDTH, 11'd8);
        run_map(1'b0);

        i_in_valid <= 1'b0;
        while (tile_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
